// File: rtl/mfg_pkg.sv
// Shared types, register codes and reset values of the multiwave function generator.
package mfg_pkg;

  localparam int DEFAULT_MAX_FRAME  = 128;
  localparam int DEFAULT_SINE_DEPTH = 256;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 32;
  localparam int SHAPE_W            = 17;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAWTOOTH = 3'd3
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_MODE    = 3'd0,
    REG_PHASE_STEP   = 3'd1,
    REG_DC_OFFSET    = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_FRAME_LENGTH = 3'd4
  } reg_e;

  typedef struct packed {
    logic        [2:0]  wave_mode;
    logic        [31:0] phase_step;
    logic signed [15:0] dc_offset;
    logic signed [15:0] amplitude;
    logic        [7:0]  frame_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wave_mode:    3'd0,
    phase_step:   32'd429496730,
    dc_offset:    16'sd0,
    amplitude:    16'sd256,
    frame_length: 8'd128
  };

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } pipe_en_t;

endpackage

// File: rtl/multiwave_function_generator_top.sv
// Top level of the multiwave function generator: registers, pipeline control, stages.
// An accepted beat passes through four stage registers in turn (frame, index, table, scale).
// Throughput: one beat per cycle while the output is not stalled.
// A stalled output holds its sample, and the stall backs up through the stages to the input.
// Reset clears the phase, the frame position, the stage valid bits and the config registers
// to their defaults; the sine table is constant logic and needs no fill after reset.
module multiwave_function_generator_top #(
  parameter int MaxFrame  = mfg_pkg::DEFAULT_MAX_FRAME,
  parameter int SineDepth = mfg_pkg::DEFAULT_SINE_DEPTH,
  parameter int IdxW      = $clog2(MaxFrame)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mfg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mfg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [15:0]               sample_o,
  output logic [IdxW-1:0]                  sample_index_o,
  output logic                             frame_end_o
);
  import mfg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  pipe_en_t en;
  logic     v_a_q, v_b_q, v_c_q, v_d_q;
  logic     accept;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_MODE:    cfg_d.wave_mode    = cfg_wdata_i[2:0];
        REG_PHASE_STEP:   cfg_d.phase_step   = cfg_wdata_i[31:0];
        REG_DC_OFFSET:    cfg_d.dc_offset    = cfg_wdata_i[15:0];
        REG_AMPLITUDE:    cfg_d.amplitude    = cfg_wdata_i[15:0];
        REG_FRAME_LENGTH: cfg_d.frame_length = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en.d   = !v_d_q || !out_stall_i;
    en.c   = !v_c_q || en.d;
    en.b   = !v_b_q || en.c;
    en.a   = !v_a_q || en.b;
    accept = in_valid_i && en.a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (en.a) v_a_q <= in_valid_i;
      if (en.b) v_b_q <= v_a_q;
      if (en.c) v_c_q <= v_b_q;
      if (en.d) v_d_q <= v_c_q;
    end
  end

  logic [31:0]               phase_a;
  logic [IdxW-1:0]           pos_a, pos_c;
  logic                      last_a, last_c;
  logic signed [SHAPE_W-1:0] shape_c;

  mfg_frame #(
    .MaxFrame (MaxFrame),
    .IdxW     (IdxW)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .en_i      (en),
    .accept_i  (accept),
    .restart_i (restart_i),
    .phase_o   (phase_a),
    .pos_o     (pos_a),
    .last_o    (last_a)
  );

  mfg_shape #(
    .SineDepth (SineDepth),
    .IdxW      (IdxW)
  ) u_shape (
    .clk_i   (clk_i),
    .cfg_i   (cfg_q),
    .en_i    (en),
    .phase_i (phase_a),
    .pos_i   (pos_a),
    .last_i  (last_a),
    .shape_o (shape_c),
    .pos_o   (pos_c),
    .last_o  (last_c)
  );

  mfg_scale #(
    .IdxW (IdxW)
  ) u_scale (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .en_i     (en),
    .shape_i  (shape_c),
    .pos_i    (pos_c),
    .last_i   (last_c),
    .sample_o (sample_o),
    .pos_o    (sample_index_o),
    .last_o   (frame_end_o)
  );

  assign in_stall_o  = !en.a;
  assign out_valid_o = v_d_q;

endmodule

// File: rtl/mfg_frame.sv
// Phase accumulator, frame position tracking and the first pipeline stage.
module mfg_frame #(
  parameter int MaxFrame = mfg_pkg::DEFAULT_MAX_FRAME,
  parameter int IdxW     = $clog2(MaxFrame)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfg_pkg::cfg_t     cfg_i,
  input  mfg_pkg::pipe_en_t en_i,
  input  logic              accept_i,
  input  logic              restart_i,
  output logic [31:0]       phase_o,
  output logic [IdxW-1:0]   pos_o,
  output logic              last_o
);
  import mfg_pkg::*;

  localparam int LenW = $clog2(MaxFrame + 1);

  logic [31:0]     phase_acc_q, phase_acc_d;
  logic [IdxW-1:0] frame_pos_q, frame_pos_d;
  logic [31:0]     phase_a_q;
  logic [IdxW-1:0] pos_a_q;
  logic            last_a_q;

  logic [LenW-1:0] len;
  logic [31:0]     ph;
  logic [IdxW-1:0] pos;
  logic            last;

  always_comb begin
    if (cfg_i.frame_length == 8'd0) begin
      len = LenW'(1);
    end else if (32'(cfg_i.frame_length) > 32'(MaxFrame)) begin
      len = LenW'(MaxFrame);
    end else begin
      len = LenW'(cfg_i.frame_length);
    end

    ph  = restart_i ? 32'd0 : phase_acc_q;
    pos = restart_i ? '0 : frame_pos_q;
    if (LenW'(pos) >= len) begin
      pos = IdxW'(len - LenW'(1));
    end
    last = (LenW'(pos) + LenW'(1)) >= len;

    phase_acc_d = phase_acc_q;
    frame_pos_d = frame_pos_q;
    if (accept_i) begin
      if (last) begin
        phase_acc_d = 32'd0;
        frame_pos_d = '0;
      end else begin
        phase_acc_d = ph + cfg_i.phase_step;
        frame_pos_d = pos + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= 32'd0;
      frame_pos_q <= '0;
    end else begin
      phase_acc_q <= phase_acc_d;
      frame_pos_q <= frame_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      phase_a_q <= ph;
      pos_a_q   <= pos;
      last_a_q  <= last;
    end
  end

  assign phase_o = phase_a_q;
  assign pos_o   = pos_a_q;
  assign last_o  = last_a_q;

endmodule

// File: rtl/mfg_shape.sv
// Waveform shape stages: sine table index, quarter-wave lookup and linear shapes.
module mfg_shape #(
  parameter int SineDepth = mfg_pkg::DEFAULT_SINE_DEPTH,
  parameter int IdxW      = $clog2(mfg_pkg::DEFAULT_MAX_FRAME)
) (
  input  logic                                clk_i,
  input  mfg_pkg::cfg_t                       cfg_i,
  input  mfg_pkg::pipe_en_t                   en_i,
  input  logic [31:0]                         phase_i,
  input  logic [IdxW-1:0]                     pos_i,
  input  logic                                last_i,
  output logic signed [mfg_pkg::SHAPE_W-1:0]  shape_o,
  output logic [IdxW-1:0]                     pos_o,
  output logic                                last_o
);
  import mfg_pkg::*;

  localparam int          IW    = $clog2(4 * SineDepth);
  localparam int          AddrW = $clog2(SineDepth + 1);
  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam logic [63:0] TaylorDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / TaylorDiv[n-1];
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

  logic [14:0] sine_rom [SineDepth+1];

  for (genvar k = 0; k <= SineDepth; k++) begin : g_rom
    localparam logic [63:0] X = (PiQ30 * 64'(k)) / (2 * SineDepth);
    assign sine_rom[k] = sine_entry(X);
  end

  logic [31+IW:0]             prod;
  logic [IW-1:0]              idx_b_q;
  logic signed [SHAPE_W-1:0]  lin, lin_b_q;
  logic [2:0]                 mode_b_q;
  logic [IdxW-1:0]            pos_b_q, pos_c_q;
  logic                       last_b_q, last_c_q;
  logic signed [SHAPE_W-1:0]  shape_c_q;

  logic [15:0]                u;
  logic signed [17:0]         dev, tri_v;

  always_comb begin
    prod = {{IW{1'b0}}, phase_i} * (32 + IW)'(4 * SineDepth);
    u    = phase_i[31:16];
    dev  = $signed({2'b00, u}) - 18'sd32768;
    if (dev < 0) begin
      dev = -dev;
    end
    tri_v = (dev <<< 1) - 18'sd32768;
    case (cfg_i.wave_mode)
      WAVE_SQUARE:   lin = phase_i[31] ? 17'sd32768 : -17'sd32768;
      WAVE_TRIANGLE: lin = tri_v[SHAPE_W-1:0];
      WAVE_SAWTOOTH: lin = $signed({~u[15], ~u[15], u[14:0]});
      default:       lin = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      idx_b_q  <= prod[31+IW:32];
      lin_b_q  <= lin;
      mode_b_q <= cfg_i.wave_mode;
      pos_b_q  <= pos_i;
      last_b_q <= last_i;
    end
  end

  logic [1:0]                 quad;
  logic [IW-1:0]              base;
  logic [AddrW-1:0]           rem, addr;
  logic [14:0]                rom_val;
  logic signed [SHAPE_W-1:0]  sine_v;

  always_comb begin
    if (idx_b_q < IW'(SineDepth)) begin
      quad = 2'd0;
      base = '0;
    end else if (idx_b_q < IW'(2 * SineDepth)) begin
      quad = 2'd1;
      base = IW'(SineDepth);
    end else if (idx_b_q < IW'(3 * SineDepth)) begin
      quad = 2'd2;
      base = IW'(2 * SineDepth);
    end else begin
      quad = 2'd3;
      base = IW'(3 * SineDepth);
    end
    rem     = AddrW'(idx_b_q - base);
    addr    = quad[0] ? (AddrW'(SineDepth) - rem) : rem;
    rom_val = sine_rom[addr];
    sine_v  = quad[1] ? -$signed({2'b00, rom_val}) : $signed({2'b00, rom_val});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      shape_c_q <= (mode_b_q == WAVE_SINE) ? sine_v : lin_b_q;
      pos_c_q   <= pos_b_q;
      last_c_q  <= last_b_q;
    end
  end

  assign shape_o = shape_c_q;
  assign pos_o   = pos_c_q;
  assign last_o  = last_c_q;

endmodule

// File: rtl/mfg_scale.sv
// Amplitude scaling, DC offset and saturation into the output register.
module mfg_scale #(
  parameter int IdxW = $clog2(mfg_pkg::DEFAULT_MAX_FRAME)
) (
  input  logic                                clk_i,
  input  mfg_pkg::cfg_t                       cfg_i,
  input  mfg_pkg::pipe_en_t                   en_i,
  input  logic signed [mfg_pkg::SHAPE_W-1:0]  shape_i,
  input  logic [IdxW-1:0]                     pos_i,
  input  logic                                last_i,
  output logic signed [15:0]                  sample_o,
  output logic [IdxW-1:0]                     pos_o,
  output logic                                last_o
);
  import mfg_pkg::*;

  logic signed [32:0] prod, rnd;
  logic signed [17:0] scaled;
  logic signed [18:0] total;
  logic signed [15:0] sat;
  logic signed [15:0] sample_q;
  logic [IdxW-1:0]    pos_q;
  logic               last_q;

  always_comb begin
    prod   = $signed(cfg_i.amplitude) * shape_i;
    rnd    = prod + 33'sd16384;
    scaled = rnd[32:15];
    total  = $signed({{3{cfg_i.dc_offset[15]}}, cfg_i.dc_offset})
           + $signed({scaled[17], scaled});
    if (total > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (total < -19'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = total[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.d) begin
      sample_q <= sat;
      pos_q    <= pos_i;
      last_q   <= last_i;
    end
  end

  assign sample_o = sample_q;
  assign pos_o    = pos_q;
  assign last_o   = last_q;

endmodule

// File: tb/mfg_sample_checker.sv
// Checker that predicts every generator sample and compares the output beats against it.
module mfg_sample_checker
  import mfg_pkg::*;
#(
  parameter int IdxW = $clog2(DEFAULT_MAX_FRAME)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  restart_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [15:0]    sample_i,
  input  logic [IdxW-1:0]       sample_index_i,
  input  logic                  frame_end_i,
  output int                    mismatches_o,
  output int                    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              MAX_FRAME  = DEFAULT_MAX_FRAME;
  localparam int              SINE_DEPTH = DEFAULT_SINE_DEPTH;
  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam int              PRINT_CAP  = 40;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [IdxW-1:0]    index;
    logic               last;
  } sample_beat_t;

  cfg_t         gen_cfg;
  logic [31:0]  phase_q;
  int unsigned  frame_pos_q;
  sample_beat_t expected_q[$];
  sample_beat_t want;
  int           sine_lut[SINE_DEPTH+1];

  function automatic int quarter_sine(int k);
    longint unsigned x, x2, term;
    longint          acc, r;
    int              n;
    x = (PI_Q30 * 64'(k)) / 64'(2 * SINE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    r = (acc * 32767 + 64'sd536870912) >>> 30;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  initial begin
    for (int k = 0; k <= SINE_DEPTH; k++) sine_lut[k] = quarter_sine(k);
  end

  function automatic longint wave_shape(logic [2:0] mode, logic [31:0] ph);
    longint unsigned slot;
    int unsigned     quad, offs;
    longint          d;
    slot = (64'(ph) * 64'(4 * SINE_DEPTH)) >> 32;
    quad = (slot / 64'(SINE_DEPTH)) % 4;
    offs = slot % 64'(SINE_DEPTH);
    d = longint'(ph[31:16]) - 32768;
    case (mode)
      WAVE_SINE: begin
        case (quad)
          0: return sine_lut[offs];
          1: return sine_lut[SINE_DEPTH - offs];
          2: return -sine_lut[offs];
          default: return -sine_lut[SINE_DEPTH - offs];
        endcase
      end
      WAVE_SQUARE: return ph[31] ? 64'sd32768 : -64'sd32768;
      WAVE_TRIANGLE: begin
        if (d < 0) d = -d;
        return 2 * d - 32768;
      end
      WAVE_SAWTOOTH: return d;
      default: return 0;
    endcase
  endfunction

  // Advances the generator state by one sample and returns the beat it produces.
  function automatic sample_beat_t next_sample(logic restart);
    int unsigned  len;
    longint       total;
    sample_beat_t beat;
    len = gen_cfg.frame_length;
    if (len < 1) len = 1;
    if (len > MAX_FRAME) len = MAX_FRAME;
    if (restart) begin
      phase_q = '0;
      frame_pos_q = 0;
    end
    if (frame_pos_q >= len) frame_pos_q = len - 1;
    total = longint'($signed(gen_cfg.dc_offset)) +
            ((longint'($signed(gen_cfg.amplitude)) * wave_shape(gen_cfg.wave_mode, phase_q)
              + 16384) >>> 15);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    beat.sample = total[15:0];
    beat.index = frame_pos_q[IdxW-1:0];
    beat.last = (frame_pos_q + 1 >= len);
    if (beat.last) begin
      phase_q = '0;
      frame_pos_q = 0;
    end else begin
      phase_q = phase_q + gen_cfg.phase_step;
      frame_pos_q = frame_pos_q + 1;
    end
    return beat;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches_o < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_cfg = CFG_RESET;
      phase_q = '0;
      frame_pos_q = 0;
      expected_q.delete();
      mismatches_o = 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVE_MODE:    gen_cfg.wave_mode = cfg_wdata_i[2:0];
          REG_PHASE_STEP:   gen_cfg.phase_step = cfg_wdata_i;
          REG_DC_OFFSET:    gen_cfg.dc_offset = cfg_wdata_i[15:0];
          REG_AMPLITUDE:    gen_cfg.amplitude = cfg_wdata_i[15:0];
          REG_FRAME_LENGTH: gen_cfg.frame_length = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("output beat with no sample expected");
        end else begin
          want = expected_q.pop_front();
          if (sample_i !== want.sample)
            report_mismatch($sformatf("sample got %0d want %0d", sample_i, want.sample));
          if (sample_index_i !== want.index)
            report_mismatch($sformatf("sample_index got %0d want %0d",
                                      sample_index_i, want.index));
          if (frame_end_i !== want.last)
            report_mismatch($sformatf("frame_end got %b want %b", frame_end_i, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(next_sample(restart_i));
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// File: tb/multiwave_function_generator_top_test.sv
// Testbench top: drives the generator with directed and random beats and reports the verdict.
module multiwave_function_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfg_pkg::*;

  localparam int                   IdxW         = $clog2(DEFAULT_MAX_FRAME);
  localparam int                   DRAIN_CYCLES = 8;
  localparam int unsigned          CYCLE_LIMIT  = 400000;
  localparam int                   RANDOM_ITEMS = 1000;
  localparam logic [2:0]           WAVE_DC_ONLY = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  restart   = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    sample;
  logic [IdxW-1:0]       sample_index;
  logic                  frame_end;
  int                    mismatches;
  int                    outstanding;
  int unsigned           cycles    = 0;
  int unsigned           stall_tick;
  stall_style_e          stall_style;

  multiwave_function_generator_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sample_o       (sample),
    .sample_index_o (sample_index),
    .frame_end_o    (frame_end)
  );

  mfg_sample_checker #(.IdxW(IdxW)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .restart_i      (restart),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .sample_i       (sample),
    .sample_index_i (sample_index),
    .frame_end_i    (frame_end),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_tick <= 0;
      stall_style <= STALL_NONE;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 89 == 0) stall_style <= stall_style_e'($urandom_range(0, 3));
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_tick[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic restart_bit);
    in_valid <= 1'b1;
    restart <= restart_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_items(input int count, input int restart_odds);
    int burst, gap;
    while (count > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      while (burst > 0 && count > 0) begin
        send_beat($urandom_range(1, restart_odds) == 1);
        burst--;
        count--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic shuffle_config();
    logic [15:0] v16;
    logic [31:0] v32;
    logic [7:0]  v8;
    if ($urandom_range(0, 1)) write_reg(REG_WAVE_MODE, $urandom());
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v32 = $urandom();
        1: v32 = $urandom_range(0, 1 << 20);
        2: v32 = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: v32 = $urandom() >> $urandom_range(0, 31);
      endcase
      write_reg(REG_PHASE_STEP, v32);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v16 = 16'h7FFF;
        1: v16 = 16'h8000;
        2: v16 = 16'($urandom_range(0, 1024)) - 16'd512;
        default: v16 = 16'($urandom());
      endcase
      write_reg(REG_DC_OFFSET, {16'($urandom()), v16});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v16 = 16'h7FFF;
        1: v16 = 16'h8000;
        2: v16 = 16'($urandom_range(0, 512));
        default: v16 = 16'($urandom());
      endcase
      write_reg(REG_AMPLITUDE, {16'($urandom()), v16});
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0: v8 = 8'd0;
        1: v8 = 8'($urandom_range(129, 255));
        2: v8 = 8'd1;
        3: v8 = 8'd128;
        default: v8 = 8'($urandom_range(1, 64));
      endcase
      write_reg(REG_FRAME_LENGTH, {24'($urandom()), v8});
    end
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_FRAME_LENGTH) + 1, (1 << CFG_IDX_W) - 1)),
                $urandom());
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent, n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    wait_drained();

    write_reg(REG_WAVE_MODE, {29'($urandom()), WAVE_SINE});
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    write_reg(REG_FRAME_LENGTH, 32'd8);
    cfg_we <= 1'b0;
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    wait_drained();

    write_reg(REG_WAVE_MODE, {29'd0, WAVE_SQUARE});
    write_reg(REG_AMPLITUDE, 32'hFFFF_8000);
    write_reg(REG_DC_OFFSET, 32'h0000_7FFF);
    write_reg(REG_FRAME_LENGTH, 32'hFFFF_FF00);
    cfg_we <= 1'b0;
    send_beat(1'b0);
    send_beat(1'b1);
    wait_drained();

    write_reg(REG_WAVE_MODE, {29'd0, WAVE_TRIANGLE});
    write_reg(REG_PHASE_STEP, 32'h8000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    write_reg(REG_DC_OFFSET, 32'h0000_8000);
    write_reg(REG_FRAME_LENGTH, 32'd200);
    cfg_we <= 1'b0;
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    wait_drained();

    write_reg(REG_WAVE_MODE, {29'd0, WAVE_SAWTOOTH});
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE, 32'h0000_8000);
    cfg_we <= 1'b0;
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    wait_drained();

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_WAVE_MODE, {29'h1FFF_FFFF, WAVE_DC_ONLY});
    write_reg(REG_DC_OFFSET, 32'h0000_7FFF);
    write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    cfg_we <= 1'b0;
    send_beat(1'b0);
    send_beat(1'b0);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      shuffle_config();
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(130, 260) : $urandom_range(10, 100);
      send_items(n, ($urandom_range(0, 2) == 0) ? 1000 : $urandom_range(2, 64));
      sent += n;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
